// File: hw/rtl/mpmd_pkg.sv
// Shared types, constants and the control program of the multichannel PID drive.
// Holds the microcode table, the control word layout and the fixed-point helpers.
// No dependencies; every other file of the block imports this package.
package mpmd_pkg;

	localparam int NUM_CHANNELS_DEF = 4;

	// Field widths of the stream payloads.
	localparam int CH_W    = 2;
	localparam int SPEED_W = 32;
	localparam int DUTY_W  = 23;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Arithmetic widths: one signed 33x33 multiplier and a wide saturation input.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RND_W  = PROD_W - 16;
	localparam int SAT_W  = 52;
	localparam int FACC_W = 52;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 23'd6553600;

	// Register reset values.
	localparam logic [31:0] RST_GAIN_PROP       = 32'd393216;
	localparam logic [31:0] RST_GAIN_INT_DT     = 32'd6554;
	localparam logic [31:0] RST_GAIN_DER_PER_DT = 32'd983040;
	localparam logic [15:0] RST_DERIV_ALPHA     = 16'd10923;
	localparam logic [31:0] RST_DRIVE_MIN       = 32'hFF9C_0000;
	localparam logic [31:0] RST_DRIVE_MAX       = 32'd6553600;
	localparam logic [30:0] RST_INTEG_LIMIT     = 31'd65536000;
	localparam logic [30:0] RST_SLEW_STEP       = 31'd327680;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_INT_DT,
		REG_GAIN_DER_PER_DT,
		REG_DERIV_ALPHA,
		REG_DRIVE_MIN,
		REG_DRIVE_MAX,
		REG_INTEG_LIMIT,
		REG_SLEW_STEP
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] gain_prop;
		logic [31:0] gain_int_dt;
		logic [31:0] gain_der_per_dt;
		logic [15:0] deriv_alpha;
		logic [31:0] drive_min;
		logic [31:0] drive_max;
		logic [30:0] integ_limit;
		logic [30:0] slew_step;
	} cfg_t;

	// Datapath operation performed by a step.
	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_DIFF,
		ALU_P,
		ALU_I,
		ALU_DRAW,
		ALU_FACC,
		ALU_FILT,
		ALU_SUM,
		ALU_SLEW,
		ALU_COMMIT
	} alu_op_t;

	typedef enum logic [2:0] {
		MA_GP,
		MA_GI,
		MA_GD,
		MA_ALPHA,
		MA_ALPHA_C
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_E,
		MB_DM,
		MB_FILT,
		MB_DRAW
	} mul_b_t;

	typedef enum logic {
		JC_NEXT,
		JC_OOR
	} jmp_cond_t;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] ST_DIFF   = 4'd0;
	localparam logic [STEP_W-1:0] ST_MUL_P  = 4'd1;
	localparam logic [STEP_W-1:0] ST_MUL_I  = 4'd2;
	localparam logic [STEP_W-1:0] ST_MUL_D  = 4'd3;
	localparam logic [STEP_W-1:0] ST_MUL_F0 = 4'd4;
	localparam logic [STEP_W-1:0] ST_MUL_F1 = 4'd5;
	localparam logic [STEP_W-1:0] ST_FILT   = 4'd6;
	localparam logic [STEP_W-1:0] ST_SUM    = 4'd7;
	localparam logic [STEP_W-1:0] ST_SLEW   = 4'd8;
	localparam logic [STEP_W-1:0] ST_COMMIT = 4'd9;

	typedef struct packed {
		alu_op_t            alu;
		mul_a_t             ma;
		mul_b_t             mb;
		logic               mul_en;
		jmp_cond_t          jc;
		logic [STEP_W-1:0]  target;
		logic               last;
	} ctrl_word_t;

	// Status returned from the datapath to the sequencer.
	typedef struct packed {
		logic oor;
		logic out_free;
	} dp_status_t;

	// The control program. A multiply issued in one step is consumed by the ALU
	// in the next step, so multiplies and their post-processing overlap.
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw.alu    = ALU_NOP;
		cw.ma     = MA_GP;
		cw.mb     = MB_E;
		cw.mul_en = 1'b0;
		cw.jc     = JC_NEXT;
		cw.target = ST_DIFF;
		cw.last   = 1'b0;
		case (step)
			ST_DIFF: begin
				cw.alu    = ALU_DIFF;
				cw.jc     = JC_OOR;
				cw.target = ST_COMMIT;
			end
			ST_MUL_P: begin
				cw.ma     = MA_GP;
				cw.mb     = MB_E;
				cw.mul_en = 1'b1;
			end
			ST_MUL_I: begin
				cw.ma     = MA_GI;
				cw.mb     = MB_E;
				cw.mul_en = 1'b1;
				cw.alu    = ALU_P;
			end
			ST_MUL_D: begin
				cw.ma     = MA_GD;
				cw.mb     = MB_DM;
				cw.mul_en = 1'b1;
				cw.alu    = ALU_I;
			end
			ST_MUL_F0: begin
				cw.ma     = MA_ALPHA;
				cw.mb     = MB_FILT;
				cw.mul_en = 1'b1;
				cw.alu    = ALU_DRAW;
			end
			ST_MUL_F1: begin
				cw.ma     = MA_ALPHA_C;
				cw.mb     = MB_DRAW;
				cw.mul_en = 1'b1;
				cw.alu    = ALU_FACC;
			end
			ST_FILT:   cw.alu = ALU_FILT;
			ST_SUM:    cw.alu = ALU_SUM;
			ST_SLEW:   cw.alu = ALU_SLEW;
			ST_COMMIT: begin
				cw.alu  = ALU_COMMIT;
				cw.last = 1'b1;
			end
			default: begin
				cw.alu  = ALU_NOP;
				cw.last = 1'b1;
			end
		endcase
		return cw;
	endfunction

	// Saturate a wide signed value to the signed 32 bit range.
	function automatic logic [31:0] sat32(input logic [SAT_W-1:0] v);
		logic [31:0] r;
		if (v[SAT_W-1:31] == {(SAT_W-31){v[SAT_W-1]}})
			r = v[31:0];
		else if (v[SAT_W-1])
			r = 32'h8000_0000;
		else
			r = 32'h7FFF_FFFF;
		return r;
	endfunction

	// Round a Q32 product back to Q16: floor(v / 65536 + 1/2).
	function automatic logic [RND_W-1:0] rnd16(input logic [PROD_W-1:0] v);
		logic [PROD_W-1:0] s;
		s = v + PROD_W'(32768);
		return s[PROD_W-1:16];
	endfunction

endpackage

// File: hw/rtl/multichannel_pid_motor_drive.sv
// Multichannel PID motor drive top level: registers, stream ports, sequencer, datapath.
// Depends on mpmd_pkg, mpmd_sequencer and mpmd_datapath.
// Items are taken one at a time: s_tready is low until the ten program steps through the
// single shared multiplier have run; an out-of-range channel runs difference and commit.
// m_tvalid comes from the output register, loaded when the commit step fires.
// Reset clears all channel state to zero and loads the register defaults.
module multichannel_pid_motor_drive
	import mpmd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// channel[1:0], target_speed[33:2], measured_speed[65:34], zero fill
	input  logic [IN_TDATA_W-1:0]   s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// channel_out[1:0], drive[33:2], reverse[34], duty[57:35], zero fill
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t               cfg_q;
	logic               in_accept;
	logic               busy;
	logic               fire;
	ctrl_word_t         cw;
	dp_status_t         status;
	logic [CH_W-1:0]    channel_out;
	logic [SPEED_W-1:0] drive;
	logic               reverse;
	logic [DUTY_W-1:0]  duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop       <= RST_GAIN_PROP;
			cfg_q.gain_int_dt     <= RST_GAIN_INT_DT;
			cfg_q.gain_der_per_dt <= RST_GAIN_DER_PER_DT;
			cfg_q.deriv_alpha     <= RST_DERIV_ALPHA;
			cfg_q.drive_min       <= RST_DRIVE_MIN;
			cfg_q.drive_max       <= RST_DRIVE_MAX;
			cfg_q.integ_limit     <= RST_INTEG_LIMIT;
			cfg_q.slew_step       <= RST_SLEW_STEP;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN_PROP:       cfg_q.gain_prop       <= cfg_data;
				REG_GAIN_INT_DT:     cfg_q.gain_int_dt     <= cfg_data;
				REG_GAIN_DER_PER_DT: cfg_q.gain_der_per_dt <= cfg_data;
				REG_DERIV_ALPHA:     cfg_q.deriv_alpha     <= cfg_data[15:0];
				REG_DRIVE_MIN:       cfg_q.drive_min       <= cfg_data;
				REG_DRIVE_MAX:       cfg_q.drive_max       <= cfg_data;
				REG_INTEG_LIMIT:     cfg_q.integ_limit     <= cfg_data[30:0];
				REG_SLEW_STEP:       cfg_q.slew_step       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign s_tready  = !busy;
	assign in_accept = s_tvalid && s_tready;

	mpmd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.status (status),
		.busy   (busy),
		.fire   (fire),
		.cw     (cw)
	);

	mpmd_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_accept      (in_accept),
		.channel        (s_tdata[1:0]),
		.target_speed   (s_tdata[33:2]),
		.measured_speed (s_tdata[65:34]),
		.cw             (cw),
		.fire           (fire),
		.status         (status),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.channel_out    (channel_out),
		.drive          (drive),
		.reverse        (reverse),
		.duty           (duty)
	);

	assign m_tdata = {6'd0, duty, reverse, drive, channel_out};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("input accepted while an item was still in work");

	a_idle_means_delivered_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !fire || cw.alu == ALU_DIFF)
		else $error("program did not begin with the difference step");

	a_sign_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && reverse |-> duty != '0)
		else $error("negative drive reported with zero duty");

endmodule

// File: hw/rtl/mpmd_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on mpmd_pkg for the control word layout and the program table.
module mpmd_sequencer
	import mpmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output logic       busy,
	output logic       fire,
	output ctrl_word_t cw
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;

	assign cw   = ucode(step_q);
	assign busy = busy_q;
	// The final step waits until the output register can take the result.
	assign fire = busy_q && (!cw.last || status.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_DIFF;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ST_DIFF;
			end
		end else if (fire) begin
			if (cw.last)
				busy_q <= 1'b0;
			else if (cw.jc == JC_OOR && status.oor)
				step_q <= cw.target;
			else
				step_q <= step_q + 1'b1;
		end
	end

	a_step_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= ST_COMMIT)
		else $error("sequencer stepped past the end of the program");

	a_start_at_top: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q && step_q == ST_DIFF)
		else $error("item did not start at the first step");

	a_wait_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !fire |-> cw.last)
		else $error("sequencer stalled on a step other than the last");

endmodule

// File: hw/rtl/mpmd_datapath.sv
// Datapath of the PID drive: input latch, per-channel state, one shared
// multiplier with a product register, the ALU operations and the result register.
// Depends on mpmd_pkg; driven step by step by mpmd_sequencer.
module mpmd_datapath
	import mpmd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_accept,
	input  logic [CH_W-1:0]     channel,
	input  logic [SPEED_W-1:0]  target_speed,
	input  logic [SPEED_W-1:0]  measured_speed,
	input  ctrl_word_t          cw,
	input  logic                fire,
	output dp_status_t          status,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [CH_W-1:0]     channel_out,
	output logic [SPEED_W-1:0]  drive,
	output logic                reverse,
	output logic [DUTY_W-1:0]   duty
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [CH_W-1:0]    ch_q;
	logic [31:0]        tgt_q;
	logic [31:0]        meas_q;

	logic [31:0] integ_q [NUM_CHANNELS];
	logic [31:0] filt_q  [NUM_CHANNELS];
	logic [31:0] lastm_q [NUM_CHANNELS];
	logic [31:0] lastd_q [NUM_CHANNELS];

	logic [31:0]        e_q, dm_q, p_q, i_q, draw_q, d_q, u_q;
	logic [FACC_W-1:0]  facc_q;
	logic [PROD_W-1:0]  prod_q;

	logic               out_valid_q;
	logic [CH_W-1:0]    ch_out_q;
	logic [31:0]        drive_q;
	logic [DUTY_W-1:0]  duty_q;

	logic [IDX_W-1:0]   idx;
	logic               oor;
	logic [31:0]        integ_cur, filt_cur, lastm_cur, lastd_cur;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [RND_W-1:0]   rnd_prod;
	logic [PROD_W-1:0]  filt_sum;
	logic [31:0]        e_val, dm_val, p_val, i_sum, i_val, draw_val, d_val;
	logic [31:0]        lim, neg_lim;
	logic [33:0]        u_sum, u_lo, u_hi, u_clamp;
	logic [33:0]        delta, slew34;
	logic [31:0]        slew_val;
	logic [32:0]        u33, mag33;
	logic               commit_go;

	assign idx = IDX_W'(ch_q);
	assign oor = {30'd0, ch_q} >= 32'(NUM_CHANNELS);

	assign integ_cur = integ_q[idx];
	assign filt_cur  = filt_q[idx];
	assign lastm_cur = lastm_q[idx];
	assign lastd_cur = lastd_q[idx];

	assign commit_go       = fire && cw.alu == ALU_COMMIT;
	assign status.oor      = oor;
	assign status.out_free = !out_valid_q || out_ready;

	// Multiplier operands, all as signed 33 bit values.
	always_comb begin
		case (cw.ma)
			MA_GP:      mul_a = {cfg.gain_prop[31], cfg.gain_prop};
			MA_GI:      mul_a = {cfg.gain_int_dt[31], cfg.gain_int_dt};
			MA_GD:      mul_a = {cfg.gain_der_per_dt[31], cfg.gain_der_per_dt};
			MA_ALPHA:   mul_a = {17'd0, cfg.deriv_alpha};
			MA_ALPHA_C: mul_a = 33'd65536 - {17'd0, cfg.deriv_alpha};
			default:    mul_a = '0;
		endcase
		case (cw.mb)
			MB_E:    mul_b = {e_q[31], e_q};
			MB_DM:   mul_b = {dm_q[31], dm_q};
			MB_FILT: mul_b = {filt_cur[31], filt_cur};
			MB_DRAW: mul_b = {draw_q[31], draw_q};
			default: mul_b = '0;
		endcase
	end

	// Full-width signed product of the two operands.
	assign mul_p = $signed(mul_a) * $signed(mul_b);

	always_comb begin
		e_val  = sat32(SAT_W'($signed(tgt_q)) - SAT_W'($signed(meas_q)));
		dm_val = sat32(SAT_W'($signed(meas_q)) - SAT_W'($signed(lastm_cur)));

		rnd_prod = rnd16(prod_q);
		p_val    = sat32(SAT_W'($signed(rnd_prod)));

		// Integrator: saturating add, then the symmetric clamp.
		i_sum   = sat32(SAT_W'($signed(integ_cur)) + SAT_W'($signed(rnd_prod)));
		lim     = {1'b0, cfg.integ_limit};
		neg_lim = 32'd0 - lim;
		if ($signed(i_sum) > $signed(lim))
			i_val = lim;
		else if ($signed(i_sum) < $signed(neg_lim))
			i_val = neg_lim;
		else
			i_val = i_sum;

		draw_val = sat32(SAT_W'(0) - SAT_W'($signed(rnd_prod)));

		filt_sum = PROD_W'($signed(facc_q)) + prod_q;
		d_val    = sat32(SAT_W'($signed(rnd16(filt_sum))));

		// Upper clamp first, lower clamp last, so inverted limits give drive_min.
		u_sum = 34'($signed(p_q)) + 34'($signed(i_q)) + 34'($signed(d_q));
		u_hi  = 34'($signed(cfg.drive_max));
		u_lo  = 34'($signed(cfg.drive_min));
		u_clamp = ($signed(u_sum) > $signed(u_hi)) ? u_hi : u_sum;
		if ($signed(u_clamp) < $signed(u_lo))
			u_clamp = u_lo;

		delta  = 34'($signed(u_q)) - 34'($signed(lastd_cur));
		slew34 = {3'd0, cfg.slew_step};
		if ($signed(delta) > $signed(slew34))
			slew_val = sat32(SAT_W'($signed(lastd_cur)) + SAT_W'(slew34));
		else if ($signed(delta) < $signed(34'd0 - slew34))
			slew_val = sat32(SAT_W'($signed(lastd_cur)) - SAT_W'(slew34));
		else
			slew_val = u_q;

		u33   = {u_q[31], u_q};
		mag33 = u_q[31] ? (33'd0 - u33) : u33;
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_q   <= channel;
			tgt_q  <= target_speed;
			meas_q <= measured_speed;
		end
		if (fire && cw.mul_en)
			prod_q <= mul_p;
		if (fire) begin
			case (cw.alu)
				ALU_DIFF: begin
					e_q  <= e_val;
					dm_q <= dm_val;
				end
				ALU_P:    p_q    <= p_val;
				ALU_I:    i_q    <= i_val;
				ALU_DRAW: draw_q <= draw_val;
				ALU_FACC: facc_q <= prod_q[FACC_W-1:0];
				ALU_FILT: d_q    <= d_val;
				ALU_SUM:  u_q    <= u_clamp[31:0];
				ALU_SLEW: u_q    <= slew_val;
				default: ;
			endcase
		end
		if (commit_go) begin
			ch_out_q <= ch_q;
			drive_q  <= oor ? 32'd0 : u_q;
			if (oor)
				duty_q <= '0;
			else if (mag33 > {10'd0, DUTY_FULL})
				duty_q <= DUTY_FULL;
			else
				duty_q <= mag33[DUTY_W-1:0];
		end
	end

	// Per-channel controller state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				integ_q[i] <= '0;
				filt_q[i]  <= '0;
				lastm_q[i] <= '0;
				lastd_q[i] <= '0;
			end
		end else if (commit_go && !oor) begin
			integ_q[idx] <= i_q;
			filt_q[idx]  <= d_q;
			lastm_q[idx] <= meas_q;
			lastd_q[idx] <= u_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign channel_out = ch_out_q;
	assign drive       = drive_q;
	assign reverse     = drive_q[31];
	assign duty        = duty_q;

	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |-> status.out_free)
		else $error("result committed while the output register was full");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> out_valid_q)
		else $error("committed result not presented");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && oor |=> drive_q == 32'd0 && duty_q == '0)
		else $error("out-of-range channel produced a nonzero drive");

endmodule

// File: bench/tb_top.sv
// Testbench for the multichannel PID motor drive: drives speed items with bursts and gaps,
// stalls the result side, and checks every result against a bench PID model or known values.
// Depends on mpmd_pkg and multichannel_pid_motor_drive.
module tb_top;
	import mpmd_pkg::*;

	localparam int NCH = NUM_CHANNELS_DEF;
	// Watchdog bound on the whole run; reaching it ends the run as a failure.
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 130;
	localparam int NUM_PHASES  = 8;

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic signed [31:0] tgt;
		logic signed [31:0] meas;
	} speed_req_t;

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic signed [31:0] drive;
		logic               reverse;
		logic [DUTY_W-1:0]  duty;
	} drive_res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		reg_idx_t   idx;
		logic [31:0] value;
		speed_req_t req;
		bit         typed;
		drive_res_t want;
	} dir_row_t;

	typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;

	typedef enum logic [2:0] {
		SET_DEFAULT, SET_ALL_MAX, SET_ALL_MIN, SET_INVERTED, SET_RANDOM
	} setting_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Register copy and per-channel controller state of the model.
	longint kp, ki_dt, kd_dt, alpha, dmin, dmax, ilim, slew;
	longint integ_acc [NCH];
	longint deriv_filt [NCH];
	longint last_meas [NCH];
	longint last_drive [NCH];

	drive_res_t pending_drive [$];
	dir_row_t   dir_tab [$];

	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_loaded = 0;
	int burst_left = 0;

	rdy_mode_t  ready_mode = RDY_ALWAYS;
	int         mode_left = 0;
	logic [7:0] stall_pat = 8'h01;

	multichannel_pid_motor_drive dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic longint sat_s32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// floor(v / 2^16 + 1/2) with an arithmetic shift
	function automatic longint round_q16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic void model_reset();
		for (int i = 0; i < NCH; i++) begin
			integ_acc[i] = 0;
			deriv_filt[i] = 0;
			last_meas[i] = 0;
			last_drive[i] = 0;
		end
		kp = longint'($signed(RST_GAIN_PROP));
		ki_dt = longint'($signed(RST_GAIN_INT_DT));
		kd_dt = longint'($signed(RST_GAIN_DER_PER_DT));
		alpha = longint'(RST_DERIV_ALPHA);
		dmin = longint'($signed(RST_DRIVE_MIN));
		dmax = longint'($signed(RST_DRIVE_MAX));
		ilim = longint'(RST_INTEG_LIMIT);
		slew = longint'(RST_SLEW_STEP);
	endfunction

	function automatic void apply_reg(input reg_idx_t idx, input logic [31:0] v);
		case (idx)
			REG_GAIN_PROP:       kp = longint'($signed(v));
			REG_GAIN_INT_DT:     ki_dt = longint'($signed(v));
			REG_GAIN_DER_PER_DT: kd_dt = longint'($signed(v));
			REG_DERIV_ALPHA:     alpha = longint'(v[15:0]);
			REG_DRIVE_MIN:       dmin = longint'($signed(v));
			REG_DRIVE_MAX:       dmax = longint'($signed(v));
			REG_INTEG_LIMIT:     ilim = longint'(v[30:0]);
			REG_SLEW_STEP:       slew = longint'(v[30:0]);
			default: ;
		endcase
	endfunction

	// One control update of a channel; advances that channel's state.
	function automatic drive_res_t ctrl_step(input speed_req_t r);
		longint tgt, meas, e, p, ig, dm, draw, filt, u, delta, mag;
		int c;
		drive_res_t res;
		c = int'(r.ch);
		tgt = longint'(r.tgt);
		meas = longint'(r.meas);
		e = sat_s32(tgt - meas);
		p = sat_s32(round_q16(kp * e));
		ig = sat_s32(integ_acc[c] + round_q16(ki_dt * e));
		if (ig > ilim)
			ig = ilim;
		if (ig < -ilim)
			ig = -ilim;
		dm = sat_s32(meas - last_meas[c]);
		draw = sat_s32(-round_q16(kd_dt * dm));
		filt = sat_s32(round_q16(alpha * deriv_filt[c] + (65536 - alpha) * draw));
		u = p + ig + filt;
		if (u > dmax)
			u = dmax;
		if (u < dmin)
			u = dmin;
		// The slew limit acts after the clamps and may leave the drive outside them.
		delta = u - last_drive[c];
		if (delta > slew)
			u = sat_s32(last_drive[c] + slew);
		else if (delta < -slew)
			u = sat_s32(last_drive[c] - slew);
		integ_acc[c] = ig;
		deriv_filt[c] = filt;
		last_meas[c] = meas;
		last_drive[c] = u;
		mag = (u < 0) ? -u : u;
		if (mag > longint'(DUTY_FULL))
			mag = longint'(DUTY_FULL);
		res.ch = r.ch;
		res.drive = u[31:0];
		res.reverse = (u < 0);
		res.duty = mag[DUTY_W-1:0];
		return res;
	endfunction

	function automatic cfg_t settings_for(input setting_kind_t kind);
		cfg_t c;
		int a, b;
		case (kind)
			SET_DEFAULT: begin
				c = '{RST_GAIN_PROP, RST_GAIN_INT_DT, RST_GAIN_DER_PER_DT, RST_DERIV_ALPHA,
					RST_DRIVE_MIN, RST_DRIVE_MAX, RST_INTEG_LIMIT, RST_SLEW_STEP};
			end
			SET_ALL_MAX: begin
				c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
			end
			SET_ALL_MIN: begin
				c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000,
					32'h0000_0000, 32'h0000_0000, 31'h0, 31'h0};
			end
			default: begin
				c.gain_prop = int'($urandom_range(0, 2097152)) - 1048576;
				c.gain_int_dt = int'($urandom_range(0, 262144)) - 131072;
				c.gain_der_per_dt = int'($urandom_range(0, 4194304)) - 2097152;
				if ($urandom_range(0, 3) == 0) begin
					c.gain_prop = $urandom;
					c.gain_int_dt = $urandom;
					c.gain_der_per_dt = $urandom;
				end
				c.deriv_alpha = 16'($urandom_range(0, 65535));
				a = $urandom_range(0, 20000000);
				b = $urandom_range(0, 20000000);
				c.drive_min = (kind == SET_INVERTED) ? a : -a;
				c.drive_max = (kind == SET_INVERTED) ? -b : b;
				c.integ_limit = 31'($urandom_range(0, 134217728));
				c.slew_step = 31'($urandom_range(0, 4194304));
				if ($urandom_range(0, 3) == 0)
					c.slew_step = 31'($urandom);
			end
		endcase
		return c;
	endfunction

	// Leaves cfg_we high; the caller lowers it after the last write of a batch.
	task automatic put_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		apply_reg(idx, v);
	endtask

	task automatic load_settings(input cfg_t c);
		put_reg(REG_GAIN_PROP, c.gain_prop);
		put_reg(REG_GAIN_INT_DT, c.gain_int_dt);
		put_reg(REG_GAIN_DER_PER_DT, c.gain_der_per_dt);
		// Upper bits beyond the register width are noise and must be dropped.
		put_reg(REG_DERIV_ALPHA, {16'($urandom), c.deriv_alpha});
		put_reg(REG_DRIVE_MIN, c.drive_min);
		put_reg(REG_DRIVE_MAX, c.drive_max);
		put_reg(REG_INTEG_LIMIT, {1'($urandom), c.integ_limit});
		put_reg(REG_SLEW_STEP, {1'($urandom), c.slew_step});
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_speed(input speed_req_t r, input bit typed, input drive_res_t want,
			output drive_res_t pred);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - 66){1'b0}}, r.meas, r.tgt, r.ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = ctrl_step(r);
		pending_drive.push_back(typed ? want : pred);
		items_sent++;
		burst_left--;
	endtask

	function automatic dir_row_t reg_row(input reg_idx_t idx, input logic [31:0] v);
		dir_row_t row;
		row.kind = ROW_REG;
		row.idx = idx;
		row.value = v;
		row.req = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic dir_row_t item_row(input logic [1:0] ch, input logic [31:0] tgt,
			input logic [31:0] meas);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.idx = REG_GAIN_PROP;
		row.value = '0;
		row.req = '{ch, tgt, meas};
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic dir_row_t known_row(input logic [1:0] ch, input logic [31:0] tgt,
			input logic [31:0] meas, input logic [31:0] drive, input logic rev,
			input logic [DUTY_W-1:0] duty);
		dir_row_t row;
		row = item_row(ch, tgt, meas);
		row.typed = 1'b1;
		row.want = '{ch, drive, rev, duty};
		return row;
	endfunction

	// Result side: check on each accepted item, then pick the next ready value.
	always @(posedge clk) begin
		drive_res_t got, exp_res;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[34], m_tdata[57:35]};
			results_seen++;
			if (pending_drive.size() == 0) begin
				$error("result with nothing outstanding: channel %0d drive %0d",
					got.ch, got.drive);
				fail_count++;
			end else begin
				exp_res = pending_drive.pop_front();
				if (got.ch !== exp_res.ch) begin
					$error("channel_out: expected %0d, got %0d", exp_res.ch, got.ch);
					fail_count++;
				end
				if (got.drive !== exp_res.drive) begin
					$error("drive: expected %0d, got %0d", exp_res.drive, got.drive);
					fail_count++;
				end
				if (got.reverse !== exp_res.reverse) begin
					$error("reverse: expected %0d, got %0d", exp_res.reverse, got.reverse);
					fail_count++;
				end
				if (got.duty !== exp_res.duty) begin
					$error("duty: expected %0d, got %0d", exp_res.duty, got.duty);
					fail_count++;
				end
			end
		end
		if (mode_left == 0) begin
			ready_mode = rdy_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(50, 400);
			stall_pat = 8'($urandom) | 8'h01;
		end else begin
			mode_left--;
		end
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= 1'($urandom);
			default: begin
				m_tready <= stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[7:1]};
			end
		endcase
	end

	initial begin
		setting_kind_t plan [NUM_PHASES];
		longint plant_speed [NCH];
		longint setpoint [NCH];
		speed_req_t req;
		drive_res_t pred;
		int pick;

		plan = '{SET_DEFAULT, SET_ALL_MAX, SET_ALL_MIN, SET_INVERTED, SET_RANDOM,
			SET_RANDOM, SET_INVERTED, SET_RANDOM};
		model_reset();
		for (int i = 0; i < NCH; i++) begin
			plant_speed[i] = 0;
			setpoint[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// From reset: a fresh channel with a large error moves by exactly one slew step.
		dir_tab.push_back(known_row(2'd0, 32'd0, 32'd0, 32'd0, 1'b0, 23'd0));
		dir_tab.push_back(known_row(2'd1, 32'd65536, 32'd0, 32'd327680, 1'b0, 23'd327680));
		dir_tab.push_back(known_row(2'd2, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd327680,
			1'b1, 23'd327680));
		dir_tab.push_back(known_row(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd327680,
			1'b0, 23'd327680));
		dir_tab.push_back(item_row(2'd3, 32'h7FFF_FFFF, 32'h8000_0000));
		dir_tab.push_back(item_row(2'd2, 32'h8000_0000, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(2'd0, 32'h5555_5555, 32'hAAAA_AAAA));
		dir_tab.push_back(item_row(2'd1, 32'hAAAA_AAAA, 32'h5555_5555));
		dir_tab.push_back(item_row(2'd0, 32'd3276800, 32'd0));
		dir_tab.push_back(item_row(2'd0, 32'd3276800, 32'd65536));
		dir_tab.push_back(item_row(2'd0, 32'd3276800, 32'd131072));
		// Inverted clamps: the lower clamp is applied last and wins.
		dir_tab.push_back(reg_row(REG_DRIVE_MIN, 32'd1000000));
		dir_tab.push_back(reg_row(REG_DRIVE_MAX, -32'sd1000000));
		dir_tab.push_back(reg_row(REG_SLEW_STEP, 32'h7FFF_FFFF));
		dir_tab.push_back(known_row(2'd1, 32'd0, 32'd0, 32'd1000000, 1'b0, 23'd1000000));
		// A zero slew step holds the drive.
		dir_tab.push_back(reg_row(REG_SLEW_STEP, 32'd0));
		dir_tab.push_back(known_row(2'd1, 32'h7FFF_FFFF, 32'd0, 32'd1000000, 1'b0,
			23'd1000000));
		// Slew after clamp leaves the drive outside the clamp range for a step.
		dir_tab.push_back(reg_row(REG_DRIVE_MIN, -32'sd500000));
		dir_tab.push_back(reg_row(REG_DRIVE_MAX, 32'd500000));
		dir_tab.push_back(reg_row(REG_SLEW_STEP, 32'd100000));
		dir_tab.push_back(known_row(2'd1, 32'd0, 32'd0, 32'd900000, 1'b0, 23'd900000));
		// Full-scale gains and open limits: extreme errors push intermediate sums into saturation.
		dir_tab.push_back(reg_row(REG_GAIN_PROP, 32'h7FFF_FFFF));
		dir_tab.push_back(reg_row(REG_GAIN_INT_DT, 32'h7FFF_FFFF));
		dir_tab.push_back(reg_row(REG_GAIN_DER_PER_DT, 32'h8000_0000));
		dir_tab.push_back(reg_row(REG_DERIV_ALPHA, 32'hFFFF_0000));
		dir_tab.push_back(reg_row(REG_DRIVE_MIN, 32'h8000_0000));
		dir_tab.push_back(reg_row(REG_DRIVE_MAX, 32'h7FFF_FFFF));
		dir_tab.push_back(reg_row(REG_INTEG_LIMIT, 32'hFFFF_FFFF));
		dir_tab.push_back(reg_row(REG_SLEW_STEP, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(2'd0, 32'h7FFF_FFFF, 32'h8000_0000));
		dir_tab.push_back(item_row(2'd0, 32'h8000_0000, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(2'd0, 32'h8000_0000, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(2'd0, 32'h7FFF_FFFF, 32'h8000_0000));
		dir_tab.push_back(item_row(2'd3, 32'hFFFF_FFFF, 32'd1));

		for (int i = 0; i < dir_tab.size(); i++) begin
			if (dir_tab[i].kind == ROW_REG) begin
				if (i == 0 || dir_tab[i-1].kind != ROW_REG)
					wait_drained();
				put_reg(dir_tab[i].idx, dir_tab[i].value);
				if (i == dir_tab.size() - 1 || dir_tab[i+1].kind != ROW_REG)
					cfg_we <= 1'b0;
			end else begin
				send_speed(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want, pred);
			end
		end

		// Random part: mostly closed-loop traffic against a crude motor per channel,
		// with some moderate and some full-range noise mixed in.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			load_settings(settings_for(plan[ph]));
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				req.ch = CH_W'($urandom_range(0, NCH - 1));
				if (pick < 72) begin
					if ($urandom_range(0, 9) == 0)
						setpoint[req.ch] = longint'($urandom_range(0, 6553600)) - 3276800;
					req.tgt = 32'(setpoint[req.ch]);
					req.meas = 32'(sat_s32(plant_speed[req.ch]
						+ longint'($urandom_range(0, 4000)) - 2000));
				end else if (pick < 88) begin
					req.tgt = int'($urandom_range(0, 33554432)) - 16777216;
					req.meas = int'($urandom_range(0, 33554432)) - 16777216;
				end else begin
					req.tgt = $urandom;
					req.meas = $urandom;
				end
				send_speed(req, 1'b0, '0, pred);
				plant_speed[req.ch] += (longint'(pred.drive) - plant_speed[req.ch]) >>> 3;
			end
		end

		s_tvalid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d speed items sent under %0d register settings, %0d results checked",
			items_sent, settings_loaded + 1, results_seen);
		$display("covered: field extremes, inverted clamps, slew past clamps, saturation");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
